// ===== src/tlrqa_pkg.sv =====
// ----------------------------------------------------------------------------
// tlrqa_pkg: shared definitions for the three-level ready queue arbiter
// Sizes, field widths, status and class codes, and the register map.
// ----------------------------------------------------------------------------
package tlrqa_pkg;

   // Sizing
   localparam int RUNNERS      = 8;
   localparam int QUEUE_DEPTH  = 64;
   localparam int HANDLE_COUNT = 64;
   localparam int NUM_CLASSES  = 3;
   localparam int NUM_QUEUES   = RUNNERS * NUM_CLASSES;
   localparam int STORE_DEPTH  = NUM_QUEUES * QUEUE_DEPTH;

   // Field widths
   localparam int RUNNER_W = 3;
   localparam int HANDLE_W = 6;
   localparam int CLASS_W  = 2;
   localparam int STATUS_W = 2;
   localparam int ACTIVE_W = 4;
   localparam int USAGE_W  = 32;

   // Derived widths
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int QIDX_W  = $clog2(NUM_QUEUES);
   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int HCNT_W  = $clog2(HANDLE_COUNT + 1);

   // Starvation boost margin
   localparam logic [USAGE_W-1:0] BOOST_MARGIN = USAGE_W'(8);

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ACTIVE_RUNNERS = 1'b0;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_HIGH    = 2'd0,
      CLASS_MED     = 2'd1,
      CLASS_LOW     = 2'd2,
      CLASS_INVALID = 2'd3
   } prio_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_BAD   = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

endpackage

// ===== src/three_level_ready_queue_arbiter_unit.sv =====
// ----------------------------------------------------------------------------
// three_level_ready_queue_arbiter_unit: per-runner three-class ready queues
// Push appends a task handle to a runner's high, medium or low queue; pop
// serves high, medium, low, or low first when high usage runs ahead of low.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  request   | start / busy              | req_op, req_runner, req_task_handle,
//            |                           | req_prio_class
//  response  | rsp_valid (one cycle)     | rsp_status, rsp_popped_handle,
//            |                           | rsp_served_class
//  csr       | APB psel/penable/pready   | paddr, pwdata, prdata
//
// One transaction per cycle; busy stays low. A response passes through the
// input register and then the result register, which holds the queue
// memory's registered read port.
// Reset is synchronous and clears pointers, fill counts, usage counters and
// active_runners; the queue memory is not cleared, the fill counts guard it.
// The receiver cannot stall, so responses never back up.
// ----------------------------------------------------------------------------
module three_level_ready_queue_arbiter_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_op,
   input  logic [tlrqa_pkg::RUNNER_W-1:0]        req_runner,
   input  logic [tlrqa_pkg::HANDLE_W-1:0]        req_task_handle,
   input  logic [tlrqa_pkg::CLASS_W-1:0]         req_prio_class,
   // response channel
   output logic                                  rsp_valid,
   output logic [tlrqa_pkg::STATUS_W-1:0]        rsp_status,
   output logic [tlrqa_pkg::HANDLE_W-1:0]        rsp_popped_handle,
   output logic [tlrqa_pkg::CLASS_W-1:0]         rsp_served_class,
   // configuration port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [tlrqa_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [tlrqa_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [tlrqa_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                  pready
);

   localparam int NC = tlrqa_pkg::NUM_CLASSES;
   localparam int NR = tlrqa_pkg::RUNNERS;

   // Configuration register
   logic [tlrqa_pkg::ACTIVE_W-1:0] active_ff;

   // Input register
   logic                              req_valid_ff;
   tlrqa_pkg::op_type                 op_ff;
   logic [tlrqa_pkg::RUNNER_W-1:0]    runner_ff;
   logic [tlrqa_pkg::HANDLE_W-1:0]    handle_ff;
   logic [tlrqa_pkg::CLASS_W-1:0]     class_ff;

   // Queue bookkeeping, one array per class indexed by runner
   logic [tlrqa_pkg::PTR_W-1:0]   head_ff  [NC][NR];
   logic [tlrqa_pkg::PTR_W-1:0]   tail_ff  [NC][NR];
   logic [tlrqa_pkg::FILL_W-1:0]  fill_ff  [NC][NR];
   logic [tlrqa_pkg::USAGE_W-1:0] usage_ff [NC][NR];

   // Queue storage
   logic [tlrqa_pkg::HANDLE_W-1:0] store_mem [tlrqa_pkg::STORE_DEPTH];

   // Result register
   logic                              rsp_valid_ff;
   tlrqa_pkg::status_type             status_ff;
   logic [tlrqa_pkg::CLASS_W-1:0]     served_ff;
   logic                              pop_ok_ff;
   logic [tlrqa_pkg::HANDLE_W-1:0]    rd_data_ff;

   // Decision logic
   logic                              csr_write;
   logic [tlrqa_pkg::ACTIVE_W-1:0]    eff_runners;
   logic                              runner_ok;
   logic                              handle_ok;
   logic [tlrqa_pkg::FILL_W-1:0]      fill_row  [NC];
   logic [tlrqa_pkg::PTR_W-1:0]       head_row  [NC];
   logic [tlrqa_pkg::PTR_W-1:0]       tail_row  [NC];
   logic [tlrqa_pkg::USAGE_W-1:0]     usage_high;
   logic [tlrqa_pkg::USAGE_W-1:0]     usage_low;
   logic                              boost_hit;
   logic [1:0]                        push_cls;
   logic [1:0]                        pop_cls;
   logic                              pop_any;
   logic                              push_ok;
   logic                              pop_ok;
   logic [1:0]                        upd_cls;
   logic [tlrqa_pkg::PTR_W-1:0]       upd_ptr;
   logic [tlrqa_pkg::PTR_W-1:0]       upd_ptr_next;
   logic [tlrqa_pkg::QIDX_W-1:0]      qidx;
   logic [tlrqa_pkg::ADDR_W-1:0]      mem_addr;
   tlrqa_pkg::status_type             status_in;
   logic [tlrqa_pkg::CLASS_W-1:0]     served_in;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign prdata = tlrqa_pkg::CSR_DATA_W'(active_ff);

   // Complete an APB write on the access cycle
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (csr_write && (paddr[2] == tlrqa_pkg::REG_ACTIVE_RUNNERS)) begin
         active_ff <= pwdata[tlrqa_pkg::ACTIVE_W-1:0];
      end
   end

   // Capture the incoming transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= tlrqa_pkg::op_type'(req_op);
      runner_ff <= req_runner;
      handle_ff <= req_task_handle;
      class_ff  <= req_prio_class;
   end

   // Pick out the addressed runner's row in each class array
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         fill_row[c] = fill_ff[c][runner_ff];
         head_row[c] = head_ff[c][runner_ff];
         tail_row[c] = tail_ff[c][runner_ff];
      end
      usage_high = usage_ff[tlrqa_pkg::CLASS_HIGH][runner_ff];
      usage_low  = usage_ff[tlrqa_pkg::CLASS_LOW][runner_ff];
   end

   // Validate runner and handle
   always_comb begin
      if (active_ff > tlrqa_pkg::ACTIVE_W'(NR)) begin
         eff_runners = tlrqa_pkg::ACTIVE_W'(NR);
      end else begin
         eff_runners = active_ff;
      end
      runner_ok = tlrqa_pkg::ACTIVE_W'(runner_ff) < eff_runners;
      handle_ok = (handle_ff != '0) &&
                  (tlrqa_pkg::HCNT_W'(handle_ff) < tlrqa_pkg::HCNT_W'(tlrqa_pkg::HANDLE_COUNT));
   end

   // Choose the class a pop serves
   always_comb begin
      boost_hit = (usage_high > (usage_low + tlrqa_pkg::BOOST_MARGIN)) &&
                  (fill_row[tlrqa_pkg::CLASS_LOW] != '0);
      pop_any   = 1'b1;
      pop_cls   = tlrqa_pkg::CLASS_HIGH;
      priority if (boost_hit) begin
         pop_cls = tlrqa_pkg::CLASS_LOW;
      end else if (fill_row[tlrqa_pkg::CLASS_HIGH] != '0) begin
         pop_cls = tlrqa_pkg::CLASS_HIGH;
      end else if (fill_row[tlrqa_pkg::CLASS_MED] != '0) begin
         pop_cls = tlrqa_pkg::CLASS_MED;
      end else if (fill_row[tlrqa_pkg::CLASS_LOW] != '0) begin
         pop_cls = tlrqa_pkg::CLASS_LOW;
      end else begin
         pop_any = 1'b0;
      end
   end

   // Decide status, queue and pointer for this transaction
   always_comb begin
      push_cls  = (class_ff == tlrqa_pkg::CLASS_INVALID) ? tlrqa_pkg::CLASS_HIGH : class_ff;
      push_ok   = 1'b0;
      pop_ok    = 1'b0;
      served_in = tlrqa_pkg::CLASS_HIGH;
      unique case (op_ff)
         tlrqa_pkg::OP_PUSH: begin
            priority if (!runner_ok || !handle_ok ||
                         (class_ff == tlrqa_pkg::CLASS_INVALID)) begin
               status_in = tlrqa_pkg::STATUS_BAD;
            end else if (fill_row[push_cls] >=
                         tlrqa_pkg::FILL_W'(tlrqa_pkg::QUEUE_DEPTH)) begin
               status_in = tlrqa_pkg::STATUS_FULL;
            end else begin
               status_in = tlrqa_pkg::STATUS_OK;
               push_ok   = req_valid_ff;
            end
         end
         tlrqa_pkg::OP_POP: begin
            priority if (!runner_ok) begin
               status_in = tlrqa_pkg::STATUS_BAD;
            end else if (!pop_any) begin
               status_in = tlrqa_pkg::STATUS_EMPTY;
            end else begin
               status_in = tlrqa_pkg::STATUS_OK;
               pop_ok    = req_valid_ff;
               served_in = pop_cls;
            end
         end
         default: begin
            status_in = tlrqa_pkg::STATUS_BAD;
         end
      endcase

      upd_cls = (op_ff == tlrqa_pkg::OP_PUSH) ? push_cls : pop_cls;
      upd_ptr = (op_ff == tlrqa_pkg::OP_PUSH) ? tail_row[upd_cls] : head_row[upd_cls];
      if (upd_ptr == tlrqa_pkg::PTR_W'(tlrqa_pkg::QUEUE_DEPTH - 1)) begin
         upd_ptr_next = '0;
      end else begin
         upd_ptr_next = upd_ptr + 1'b1;
      end
      qidx     = tlrqa_pkg::QIDX_W'(runner_ff) * tlrqa_pkg::QIDX_W'(NC) +
                 tlrqa_pkg::QIDX_W'(upd_cls);
      mem_addr = tlrqa_pkg::ADDR_W'(qidx) * tlrqa_pkg::ADDR_W'(tlrqa_pkg::QUEUE_DEPTH) +
                 tlrqa_pkg::ADDR_W'(upd_ptr);
   end

   // Advance pointers, fill counts and usage counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NC; c++) begin
            for (int r = 0; r < NR; r++) begin
               head_ff[c][r]  <= '0;
               tail_ff[c][r]  <= '0;
               fill_ff[c][r]  <= '0;
               usage_ff[c][r] <= '0;
            end
         end
      end else if (push_ok) begin
         tail_ff[upd_cls][runner_ff] <= upd_ptr_next;
         fill_ff[upd_cls][runner_ff] <= fill_row[upd_cls] + 1'b1;
      end else if (pop_ok) begin
         head_ff[upd_cls][runner_ff]  <= upd_ptr_next;
         fill_ff[upd_cls][runner_ff]  <= fill_row[upd_cls] - 1'b1;
         usage_ff[upd_cls][runner_ff] <= usage_ff[upd_cls][runner_ff] + 1'b1;
      end
   end

   // Queue memory: write on push, registered read on pop
   always_ff @(posedge clock) begin
      if (push_ok) begin
         store_mem[mem_addr] <= handle_ff;
      end
      if (pop_ok) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pop_ok_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
         pop_ok_ff    <= pop_ok;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      served_ff <= served_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_popped_handle = pop_ok_ff ? rd_data_ff : '0;
   assign rsp_served_class  = pop_ok_ff ? served_ff : tlrqa_pkg::CLASS_HIGH;

   // A response follows only a captured transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(req_valid_ff))
      else $error("response without a captured transaction");

   // A boosted pop is served from the low queue
   assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && (op_ff == tlrqa_pkg::OP_POP) && runner_ok && boost_hit)
      |=> (rsp_served_class == tlrqa_pkg::CLASS_LOW))
      else $error("boosted pop not served from low queue");

   // A successful pop returns a nonzero handle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pop_ok_ff) |->
      ((rsp_status == tlrqa_pkg::STATUS_OK) && (rsp_popped_handle != '0)))
      else $error("successful pop returned no handle");

endmodule
